[hdl/cnm_pkg.sv]
// Package for the cosine nearest-match block: job descriptor, status codes,
// register indexes and state encodings. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cnm_pkg;

  localparam int ENT_W = 13;
  localparam int LEN_W = 9;

  localparam logic [1:0] STATUS_MATCH   = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [1:0] CFG_VECTOR_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_ENTRIES_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_MATCH_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    JOB_INVALID,
    JOB_EMPTY,
    JOB_SEARCH
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic [ENT_W-1:0]   entries;
    logic [LEN_W-1:0]   length;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_NORM,
    S_SQRT,
    S_DIVSET,
    S_DIV,
    S_DIST,
    S_CMP,
    S_LABEL,
    S_OUT
  } back_state_e;

endpackage
`default_nettype wire

[hdl/cnm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/cnm_front.sv]
// Front end: takes transactions, writes gallery, labels and query buffer,
// counts query length and classifies each finished query into a job. Uses cnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cnm_front #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_LENGTH  = 256,
  parameter int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic                 cmd_i,
  input  wire logic [7:0]           entry_index_i,
  input  wire logic [7:0]           element_index_i,
  input  wire logic                 last_i,
  input  wire logic [8:0]           vector_length_i,
  input  wire logic [8:0]           entries_in_use_i,
  output logic                      gal_we_o,
  output logic [EW+LW-1:0]          gal_waddr_o,
  output logic                      qry_we_o,
  output logic [LW-1:0]             qry_waddr_o,
  output logic                      push_o,
  output cnm_pkg::job_t             job_o
);
  localparam int JEW = cnm_pkg::ENT_W;
  localparam int JLW = cnm_pkg::LEN_W;

  logic [8:0] count_q, count_d, count_inc;
  logic       ent_ok, pos_ok;

  assign ent_ok    = 32'(entry_index_i) < MAX_ENTRIES;
  assign pos_ok    = 32'(element_index_i) < MAX_LENGTH;
  assign count_inc = (count_q == 9'd511) ? count_q : count_q + 9'd1;

  assign gal_we_o    = accept_i && !cmd_i && ent_ok && pos_ok;
  assign gal_waddr_o = {EW'(entry_index_i), LW'(element_index_i)};
  assign qry_we_o    = accept_i && cmd_i && pos_ok;
  assign qry_waddr_o = LW'(element_index_i);
  assign push_o      = accept_i && cmd_i && last_i;

  always_comb begin
    count_d = count_q;
    if (accept_i && cmd_i) begin
      count_d = last_i ? 9'd0 : count_inc;
    end
  end

  always_comb begin
    job_o.length  = JLW'(vector_length_i);
    job_o.entries = (32'(entries_in_use_i) > MAX_ENTRIES) ? JEW'(MAX_ENTRIES)
                                                          : JEW'(entries_in_use_i);
    if (vector_length_i == 9'd0 || 32'(vector_length_i) > MAX_LENGTH ||
        count_inc != vector_length_i) begin
      job_o.kind = cnm_pkg::JOB_INVALID;
    end else if (entries_in_use_i == 9'd0) begin
      job_o.kind = cnm_pkg::JOB_EMPTY;
    end else begin
      job_o.kind = cnm_pkg::JOB_SEARCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 9'd0;
    end else begin
      count_q <= count_d;
    end
  end
endmodule
`default_nettype wire

[hdl/cnm_queue.sv]
// Two-entry job queue between front and back end. Uses cnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cnm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cnm_pkg::job_t job_i,
  input  wire logic          pop_i,
  output logic               valid_o,
  output cnm_pkg::job_t      job_o
);
  cnm_pkg::job_t slot_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

[hdl/cnm_back.sv]
// Back end: walks the gallery for one job, computes cosine distance per entry
// with a MAC pipeline, iterative square root and divider, keeps the minimum. Uses cnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cnm_back #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_LENGTH  = 256,
  parameter int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 job_valid_i,
  input  wire cnm_pkg::job_t        job_i,
  output logic                      job_pop_o,
  output logic [LW-1:0]             qry_raddr_o,
  input  wire logic signed [15:0]   qry_rdata_i,
  output logic [EW+LW-1:0]          gal_raddr_o,
  input  wire logic signed [15:0]   gal_rdata_i,
  output logic [EW-1:0]             lab_raddr_o,
  input  wire logic [15:0]          lab_rdata_i,
  input  wire logic [15:0]          threshold_i,
  output logic                      active_o,
  output logic                      valid_o,
  output logic [1:0]                status_o,
  output logic [7:0]                best_entry_o,
  output logic [15:0]               best_label_o,
  output logic [15:0]               distance_o
);
  localparam int JEW = cnm_pkg::ENT_W;
  localparam int JLW = cnm_pkg::LEN_W;
  localparam int AW  = 32 + $clog2(MAX_LENGTH);
  localparam int SHW = $clog2(AW);
  localparam int DW  = AW + 1;
  localparam int RW  = DW + 2;
  localparam int NW  = AW + 16;
  localparam int CW  = $clog2(NW + 1);

  cnm_pkg::back_state_e state_q, state_d;

  logic [JEW-1:0]        n_q, e_q, best_e_q;
  logic [JLW-1:0]        len_q, i_q;
  logic                  v1_q, v2_q;
  logic signed [31:0]    pxy_q, pxx_q, pyy_q;
  logic signed [AW-1:0]  acc_xy_q;
  logic [AW-1:0]         acc_xx_q, acc_yy_q, x_q, y_q;
  logic [SHW-1:0]        sa_q, sb_q;
  logic [59:0]           v_q, res_q, bit_q;
  logic [NW-1:0]         num_q, quo_q;
  logic [DW:0]           den_q;
  logic [RW-1:0]         rem_q;
  logic [CW-1:0]         cnt_q;
  logic [15:0]           d_q, best_d_q;
  logic                  found_q;

  logic                  x_big, y_big, last_elem, last_entry, sq_ge, div_ge;
  logic [59:0]           sq_sum;
  logic [AW-1:0]         mag;
  logic [DW-1:0]         dval;
  logic [RW-1:0]         rem_sh;
  logic [16:0]           qs;
  logic [17:0]           qneg;
  logic [15:0]           dist_calc;

  assign x_big      = |x_q[AW-1:30];
  assign y_big      = |y_q[AW-1:30];
  assign last_elem  = i_q == len_q - JLW'(1);
  assign last_entry = e_q == n_q - JEW'(1);
  assign sq_sum     = res_q + bit_q;
  assign sq_ge      = v_q >= sq_sum;
  assign mag        = acc_xy_q[AW-1] ? AW'(-acc_xy_q) : AW'(acc_xy_q);
  assign dval       = DW'(res_q) << (sa_q + sb_q);
  assign rem_sh     = {rem_q[RW-2:0], num_q[NW-1]};
  assign div_ge     = rem_sh >= RW'(den_q);
  assign qs         = (quo_q >= NW'(32768)) ? 17'd32768 : quo_q[16:0];
  assign qneg       = {1'b0, qs} + 18'd16384;

  always_comb begin
    if (acc_xy_q[AW-1]) begin
      dist_calc = (qneg > 18'd32768) ? 16'd32768 : qneg[15:0];
    end else begin
      dist_calc = (qs >= 17'd16384) ? 16'd0 : 16'(17'd16384 - qs);
    end
  end

  assign qry_raddr_o = LW'(i_q);
  assign gal_raddr_o = {EW'(e_q), LW'(i_q)};
  assign lab_raddr_o = EW'(best_e_q);
  assign active_o    = state_q != cnm_pkg::S_IDLE;

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    unique case (state_q)
      cnm_pkg::S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_i.kind == cnm_pkg::JOB_SEARCH) begin
            state_d = cnm_pkg::S_ISSUE;
          end
        end
      end
      cnm_pkg::S_ISSUE:  if (last_elem) state_d = cnm_pkg::S_DRAIN;
      cnm_pkg::S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = (acc_xx_q == '0 || acc_yy_q == '0) ? cnm_pkg::S_CMP : cnm_pkg::S_NORM;
        end
      end
      cnm_pkg::S_NORM:   if (!x_big && !y_big) state_d = cnm_pkg::S_SQRT;
      cnm_pkg::S_SQRT:   if (bit_q == 60'd1) state_d = cnm_pkg::S_DIVSET;
      cnm_pkg::S_DIVSET: state_d = cnm_pkg::S_DIV;
      cnm_pkg::S_DIV:    if (cnt_q == CW'(NW - 1)) state_d = cnm_pkg::S_DIST;
      cnm_pkg::S_DIST:   state_d = cnm_pkg::S_CMP;
      cnm_pkg::S_CMP:    state_d = last_entry ? cnm_pkg::S_LABEL : cnm_pkg::S_ISSUE;
      cnm_pkg::S_LABEL:  state_d = cnm_pkg::S_OUT;
      cnm_pkg::S_OUT:    state_d = cnm_pkg::S_IDLE;
      default:           state_d = cnm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnm_pkg::S_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= state_q == cnm_pkg::S_ISSUE;
      v2_q    <= v1_q;
      valid_o <= (state_q == cnm_pkg::S_OUT) ||
                 (state_q == cnm_pkg::S_IDLE && job_valid_i &&
                  job_i.kind != cnm_pkg::JOB_SEARCH);
    end
  end

  always_ff @(posedge clk_i) begin
    pxy_q <= qry_rdata_i * gal_rdata_i;
    pxx_q <= qry_rdata_i * qry_rdata_i;
    pyy_q <= gal_rdata_i * gal_rdata_i;
    if (v2_q) begin
      acc_xy_q <= acc_xy_q + AW'(pxy_q);
      acc_xx_q <= acc_xx_q + AW'($unsigned(pxx_q));
      acc_yy_q <= acc_yy_q + AW'($unsigned(pyy_q));
    end
    unique case (state_q)
      cnm_pkg::S_IDLE: begin
        n_q      <= job_i.entries;
        len_q    <= job_i.length;
        e_q      <= '0;
        i_q      <= '0;
        found_q  <= 1'b0;
        best_e_q <= '0;
        best_d_q <= 16'd32768;
        acc_xy_q <= '0;
        acc_xx_q <= '0;
        acc_yy_q <= '0;
        status_o     <= (job_i.kind == cnm_pkg::JOB_INVALID) ? cnm_pkg::STATUS_INVALID
                                                              : cnm_pkg::STATUS_UNKNOWN;
        best_entry_o <= 8'd0;
        best_label_o <= 16'd0;
        distance_o   <= (job_i.kind == cnm_pkg::JOB_INVALID) ? 16'd0 : 16'd32768;
      end
      cnm_pkg::S_ISSUE: i_q <= i_q + JLW'(1);
      cnm_pkg::S_DRAIN: begin
        x_q  <= acc_xx_q;
        y_q  <= acc_yy_q;
        sa_q <= '0;
        sb_q <= '0;
        d_q  <= 16'd16384;
      end
      cnm_pkg::S_NORM: begin
        if (x_big) begin
          x_q  <= x_q >> 2;
          sa_q <= sa_q + SHW'(1);
        end
        if (y_big) begin
          y_q  <= y_q >> 2;
          sb_q <= sb_q + SHW'(1);
        end
        v_q   <= 60'(x_q[29:0]) * 60'(y_q[29:0]);
        res_q <= '0;
        bit_q <= 60'd1 << 58;
      end
      cnm_pkg::S_SQRT: begin
        if (sq_ge) begin
          v_q   <= v_q - sq_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      cnm_pkg::S_DIVSET: begin
        den_q <= {dval, 1'b0};
        num_q <= (NW'(mag) << 15) + NW'(dval);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
      end
      cnm_pkg::S_DIV: begin
        rem_q <= div_ge ? rem_sh - RW'(den_q) : rem_sh;
        quo_q <= {quo_q[NW-2:0], div_ge};
        num_q <= num_q << 1;
        cnt_q <= cnt_q + CW'(1);
      end
      cnm_pkg::S_DIST: d_q <= dist_calc;
      cnm_pkg::S_CMP: begin
        if (!found_q || d_q < best_d_q) begin
          best_d_q <= d_q;
          best_e_q <= e_q;
        end
        found_q  <= 1'b1;
        e_q      <= e_q + JEW'(1);
        i_q      <= '0;
        acc_xy_q <= '0;
        acc_xx_q <= '0;
        acc_yy_q <= '0;
      end
      cnm_pkg::S_LABEL: ;
      cnm_pkg::S_OUT: begin
        best_entry_o <= 8'(best_e_q);
        distance_o   <= best_d_q;
        if (best_d_q < threshold_i) begin
          status_o     <= cnm_pkg::STATUS_MATCH;
          best_label_o <= lab_rdata_i;
        end else begin
          status_o     <= cnm_pkg::STATUS_UNKNOWN;
          best_label_o <= 16'd0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[hdl/cosine_nearest_match_top.sv]
// Top level of the cosine nearest-match block: configuration registers,
// stores, front end, job queue and back end. Uses cnm_pkg and all cnm_* modules.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Drive start with one transaction (gallery write or query element);
//   it is taken at a clock edge where start is high and busy is low.
//   Gallery writes and non-final query elements may follow back to back
//   while busy is low. A query element with last_i set starts a job:
//   busy rises and stays high until the result strobe is issued.
//   A query of bad length or an empty gallery gives its result without a
//   search. A search walks n entries of len elements each through the MAC
//   pipeline, normalisation, square root and restoring divider, with NW =
//   48 + log2 of MAX_LENGTH (56 at 256) quotient bits.
//   result_valid_o marks each result for exactly one cycle; the receiver
//   cannot stall, so results are never held.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) must be written only when idle; the block does not enforce it.
//   Reset clears the query count, the job queue and the registers to their
//   defaults; gallery, label and query stores are not cleared.
module cosine_nearest_match_top #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_LENGTH  = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd_i,
  input  wire logic [7:0]         entry_index_i,
  input  wire logic [7:0]         element_index_i,
  input  wire logic signed [15:0] element_value_i,
  input  wire logic [15:0]        person_label_i,
  input  wire logic               last_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic [7:0]              best_entry_o,
  output logic [15:0]             best_label_o,
  output logic [15:0]             distance_o
);
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  logic [8:0]  vl_q, eiu_q;
  logic [15:0] thr_q;
  logic        accept, gal_we, qry_we, push, pop, job_valid, back_active;
  logic [EW+LW-1:0] gal_waddr, gal_raddr;
  logic [LW-1:0]    qry_waddr, qry_raddr;
  logic [EW-1:0]    lab_raddr;
  logic [15:0]      gal_rdata, qry_rdata, lab_rdata;
  cnm_pkg::job_t    job_in, job_out;

  assign busy   = job_valid || back_active;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q  <= 9'd256;
      eiu_q <= 9'd0;
      thr_q <= 16'd7373;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cnm_pkg::CFG_VECTOR_LENGTH:   vl_q  <= cfg_data_i[8:0];
        cnm_pkg::CFG_ENTRIES_IN_USE:  eiu_q <= cfg_data_i[8:0];
        cnm_pkg::CFG_MATCH_THRESHOLD: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cnm_front #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_LENGTH(MAX_LENGTH), .EW(EW), .LW(LW))
  u_front (
    .clk_i, .rst_ni, .accept_i(accept), .cmd_i, .entry_index_i, .element_index_i,
    .last_i,
    .vector_length_i(vl_q), .entries_in_use_i(eiu_q),
    .gal_we_o(gal_we), .gal_waddr_o(gal_waddr), .qry_we_o(qry_we),
    .qry_waddr_o(qry_waddr), .push_o(push), .job_o(job_in)
  );

  cnm_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES << LW)) u_gallery (
    .clk_i, .we_i(gal_we), .waddr_i(gal_waddr), .wdata_i(element_value_i),
    .raddr_i(gal_raddr), .rdata_o(gal_rdata)
  );

  cnm_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_labels (
    .clk_i, .we_i(gal_we), .waddr_i(gal_waddr[EW+LW-1:LW]), .wdata_i(person_label_i),
    .raddr_i(lab_raddr), .rdata_o(lab_rdata)
  );

  cnm_ram #(.WIDTH(16), .DEPTH(MAX_LENGTH)) u_query (
    .clk_i, .we_i(qry_we), .waddr_i(qry_waddr), .wdata_i(element_value_i),
    .raddr_i(qry_raddr), .rdata_o(qry_rdata)
  );

  cnm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .pop_i(pop),
    .valid_o(job_valid), .job_o(job_out)
  );

  cnm_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_LENGTH(MAX_LENGTH), .EW(EW), .LW(LW))
  u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job_out), .job_pop_o(pop),
    .qry_raddr_o(qry_raddr), .qry_rdata_i(signed'(qry_rdata)),
    .gal_raddr_o(gal_raddr), .gal_rdata_i(signed'(gal_rdata)),
    .lab_raddr_o(lab_raddr), .lab_rdata_i(lab_rdata), .threshold_i(thr_q),
    .active_o(back_active), .valid_o(result_valid_o), .status_o, .best_entry_o,
    .best_label_o, .distance_o
  );

`ifndef SYNTHESIS
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i && last_i |=> busy)
    else $error("final query element did not start a job");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == cnm_pkg::STATUS_INVALID |->
      distance_o == 16'd0 && best_entry_o == 8'd0 && best_label_o == 16'd0)
    else $error("invalid result carries nonzero fields");
  a_match_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == cnm_pkg::STATUS_MATCH |-> distance_o < thr_q)
    else $error("match reported at or above threshold");
  a_unknown_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == cnm_pkg::STATUS_UNKNOWN |-> best_label_o == 16'd0)
    else $error("unknown result carries a label");
`endif
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for cosine_nearest_match_top: directed and random gallery writes and
// query streams, checked against an in-bench cosine-distance predictor.
// Depends on cnm_pkg and the cosine_nearest_match_top RTL.
`timescale 1ns / 1ps
module tb;

  localparam int NENT = 256;
  localparam int NLEN = 256;
  localparam int ONE = 16384;
  localparam int DMAX = 32768;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry;
    logic [15:0] label;
    logic [15:0] distance;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cmd_i = 1'b0;
  logic [7:0] entry_index_i = '0;
  logic [7:0] element_index_i = '0;
  logic signed [15:0] element_value_i = '0;
  logic [15:0] person_label_i = '0;
  logic last_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [1:0] status_o;
  logic [7:0] best_entry_o;
  logic [15:0] best_label_o;
  logic [15:0] distance_o;

  cosine_nearest_match_top i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .entry_index_i, .element_index_i,
    .element_value_i, .person_label_i, .last_i, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .status_o, .best_entry_o, .best_label_o, .distance_o
  );

  always #1 clk_i = ~clk_i;

  logic signed [15:0] gallery [NENT][NLEN];
  logic [15:0] labels [NENT];
  logic signed [15:0] query [NLEN];
  int unsigned query_len;
  int unsigned vec_len, entries, threshold;
  match_t pending_matches [$];
  int mismatches = 0;
  int sent = 0;
  bit calm = 1'b0;
  int stall_cycles = 0;
  logic signed [15:0] base_vec [NLEN];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int cosine_distance(int e, int len);
    longint xy;
    longint unsigned xx, yy, den, mag, q;
    longint d, x, y;
    int a, b;
    xy = 0; xx = 0; yy = 0; a = 0; b = 0;
    for (int i = 0; i < len; i++) begin
      x = query[i];
      y = gallery[e][i];
      xy += x * y;
      xx += x * x;
      yy += y * y;
    end
    if (xx == 0 || yy == 0) return ONE;
    while ((xx >> a) >= (64'd1 << 30)) a += 2;
    while ((yy >> b) >= (64'd1 << 30)) b += 2;
    den = floor_sqrt((xx >> a) * (yy >> b)) << ((a + b) / 2);
    mag = (xy < 0) ? -xy : xy;
    q = (mag * 2 * ONE + den) / (2 * den);
    d = (xy < 0) ? ONE + longint'(q) : ONE - longint'(q);
    if (d < 0) d = 0;
    if (d > DMAX) d = DMAX;
    return int'(d);
  endfunction

  task automatic predict_match(bit cmd, int ent, int pos, int val, int lab, bit last);
    match_t m;
    int unsigned len, n, best_e;
    int best_d, d;
    if (!cmd) begin
      gallery[ent][pos] = val[15:0];
      labels[ent] = lab[15:0];
      return;
    end
    query[pos] = val[15:0];
    if (query_len < 511) query_len++;
    if (!last) return;
    len = query_len;
    query_len = 0;
    m = '0;
    if (vec_len == 0 || vec_len > NLEN || len != vec_len) begin
      m.status = cnm_pkg::STATUS_INVALID;
    end else begin
      n = (entries > NENT) ? NENT : entries;
      best_d = DMAX;
      best_e = 0;
      for (int e = 0; e < n; e++) begin
        d = cosine_distance(e, len);
        if (e == 0 || d < best_d) begin
          best_d = d;
          best_e = e;
        end
      end
      if (n > 0 && best_d < int'(threshold)) begin
        m.status = cnm_pkg::STATUS_MATCH;
        m.label = labels[best_e];
      end else begin
        m.status = cnm_pkg::STATUS_UNKNOWN;
      end
      m.entry = best_e[7:0];
      m.distance = best_d[15:0];
    end
    pending_matches = {pending_matches, m};
  endtask

  task automatic send_item(bit cmd, int ent, int pos, int val, int lab, bit last);
    cmd_i = cmd;
    entry_index_i = ent[7:0];
    element_index_i = pos[7:0];
    element_value_i = val[15:0];
    person_label_i = lab[15:0];
    last_i = last;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_match(cmd, ent & 255, pos & 255, val, lab & 16'hffff, last);
    sent++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic quiesce();
    start = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned data);
    quiesce();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data[15:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      cnm_pkg::CFG_VECTOR_LENGTH:   vec_len = data & 9'h1ff;
      cnm_pkg::CFG_ENTRIES_IN_USE:  entries = data & 9'h1ff;
      cnm_pkg::CFG_MATCH_THRESHOLD: threshold = data & 16'hffff;
      default: ;
    endcase
  endtask

  task automatic setup(int unsigned len, int unsigned n, int unsigned thr);
    write_reg(cnm_pkg::CFG_VECTOR_LENGTH, len);
    write_reg(cnm_pkg::CFG_ENTRIES_IN_USE, n);
    write_reg(cnm_pkg::CFG_MATCH_THRESHOLD, thr);
  endtask

  function automatic int rand_value();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int near_value(int v);
    int r;
    r = v + int'($urandom_range(0, 2000)) - 1000;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  task automatic send_query(int len, int mode);
    int v;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = base_vec[i];
        1: v = near_value(base_vec[i]);
        2: v = 0;
        3: v = -int'(base_vec[i]);
        default: v = rand_value();
      endcase
      send_item(1'b1, $urandom_range(0, 255), i, v, $urandom_range(0, 65535), i == len - 1);
    end
  endtask

  task automatic fill_gallery(int len, int n);
    int lab, mode, v;
    for (int e = 0; e < n; e++) begin
      lab = $urandom_range(0, 65535);
      mode = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: v = 0;
          1, 2: v = base_vec[i];
          3, 4: v = near_value(base_vec[i]);
          default: v = rand_value();
        endcase
        send_item(1'b0, e, i, v, lab, $urandom_range(0, 1));
      end
    end
  endtask

  task automatic new_base();
    for (int i = 0; i < NLEN; i++) base_vec[i] = rand_value();
  endtask

  task automatic test_reset_defaults();
    new_base();
    send_query(4, 4);
  endtask

  task automatic test_special_cases();
    new_base();
    setup(4, 4, 7373);
    for (int i = 0; i < 4; i++) begin
      send_item(1'b0, 0, i, base_vec[i], 16'hffff, 1'b0);
      send_item(1'b0, 1, i, 0, 16'h0000, 1'b1);
      send_item(1'b0, 2, i, base_vec[i], 16'h1234, 1'b0);
      send_item(1'b0, 3, i, near_value(base_vec[i]), 16'h8001, 1'b0);
    end
    send_query(4, 0);
    send_query(4, 2);
    send_query(4, 3);
    setup(4, 4, 0);
    send_query(4, 0);
    setup(4, 4, DMAX);
    send_query(4, 4);
    setup(4, 0, 7373);
    send_query(4, 1);
  endtask

  task automatic test_length_errors();
    setup(4, 2, 7373);
    send_query(3, 4);
    send_query(5, 4);
    send_query(6, 4);
    write_reg(cnm_pkg::CFG_VECTOR_LENGTH, 0);
    send_query(1, 4);
  endtask

  task automatic test_full_gallery();
    new_base();
    setup(1, NENT, DMAX);
    fill_gallery(1, NENT);
    send_query(1, 1);
    write_reg(cnm_pkg::CFG_MATCH_THRESHOLD, 0);
    send_query(1, 0);
  endtask

  task automatic test_random(int target);
    int len, n, kind;
    while (sent < target) begin
      new_base();
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
      n = $urandom_range(0, 6);
      case ($urandom_range(0, 3))
        0: setup(len, n, $urandom_range(0, DMAX));
        1: setup(len, n, DMAX);
        default: setup(len, n, $urandom_range(2000, 12000));
      endcase
      fill_gallery(len, n);
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          send_query(len, $urandom_range(0, 4));
        end else if (kind < 9) begin
          send_query((len > 1 && $urandom_range(0, 1)) ? len - 1 : len + 1, 4);
        end else begin
          repeat ($urandom_range(1, 4))
            send_item(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), rand_value(),
                      $urandom_range(0, 65535), $urandom_range(0, 1));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    match_t got, want;
    if (rst_ni && result_valid_o) begin
      got = {status_o, best_entry_o, best_label_o, distance_o};
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_matches.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    vec_len = 256;
    entries = 0;
    threshold = 7373;
    query_len = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_special_cases();
    test_length_errors();
    test_full_gallery();
    test_random(sent + 90);
    calm = 1'b1;
    test_random(sent + 40);
    start = 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hdl/cnm_pkg.sv
hdl/cnm_ram.sv
hdl/cnm_front.sv
hdl/cnm_queue.sv
hdl/cnm_back.sv
hdl/cosine_nearest_match_top.sv
test/tb.sv
